/* hw/rtl/scp_pkg.sv */
package scp_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP,
		ST_PHASE,
		ST_LFO,
		ST_DLY,
		ST_CLAMP,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_DIV,
		ST_AP,
		ST_WET,
		ST_MIXA,
		ST_MIXB,
		ST_MIXC,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		REG_MIX_DEPTH = 2'd0,
		REG_LFO_RATE  = 2'd1
	} reg_index_t;

	localparam logic [7:0]  MIX_DEPTH_RESET = 8'd0;
	localparam logic [6:0]  LFO_RATE_RESET  = 7'd42;
	localparam logic [7:0]  DEPTH_FULL      = 8'd128;
	localparam logic [31:0] PHASE_BASE      = 32'd9737;
	localparam logic [31:0] PHASE_QUARTER   = 32'h4000_0000;
	localparam int          RATE_STEP       = 2223;
	localparam int          DELAY_BASE_Q8   = 441 * 256;
	localparam int          DELAY_SWING     = 220;
	localparam int          LFO_MID         = 16384;
	localparam logic [4:0]  DIV_STEPS       = 5'd17;

	// Triangle table: rising by 257 per entry for the first half, falling after.
	function automatic logic [14:0] tri_wave(input logic [7:0] i);
		logic [14:0] ramp;
		ramp = 15'({i[6:0], 8'd0} + {8'd0, i[6:0]});
		if (!i[7]) begin
			tri_wave = ramp;
		end else begin
			tri_wave = 15'(15'h7fff - ramp);
		end
	endfunction

	function automatic logic [15:0] sat16(input logic signed [35:0] v);
		if (v > 36'sd32767) begin
			sat16 = 16'h7fff;
		end else if (v < -36'sd32768) begin
			sat16 = 16'h8000;
		end else begin
			sat16 = v[15:0];
		end
	endfunction

endpackage

/* hw/rtl/scp_ram.sv */
module scp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/stereo_chorus_allpass.sv */
// Stereo chorus with allpass fractional delay. Each accepted input item is a stereo
// pair; it yields one mixed stereo pair. The block handles one item at a time and
// takes no new item until the result of the last one is loaded into the output
// register. Most of the work on each item is done by the 17-step restoring
// divider that each channel runs for its allpass coefficient; a single shared 18x18
// multiplier does all products in sequence. A finished result waits in the output
// register, so the next item may be accepted while it is still pending. Both channels
// share one delay RAM of BUF_SIZE words; entries not yet written since reset read as
// zero by way of a fill count, so no clearing pass is needed after reset.
// Configuration writes are always taken and must be made only while the block is idle.
module stereo_chorus_allpass #(
	parameter int BUF_SIZE = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // in_left [15:0], in_right [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_left [15:0], out_right [31:16]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import scp_pkg::*;

	localparam int AW = $clog2(BUF_SIZE);

	state_t state_q, state_d;

	logic [7:0]  mix_q;
	logic [6:0]  rate_q;
	logic [31:0] phase_q;
	logic [AW-1:0] wp_q;
	logic [AW:0]   fill_q;
	logic        ch_q;
	logic [31:0] din_q;
	logic [15:0] mem_q [2];
	logic [15:0] wet_q [2];
	logic [15:0] res_q [2];

	logic signed [17:0] tria_q;
	logic signed [35:0] prod_q;
	logic signed [35:0] acc_q;
	logic signed [17:0] mul_a, mul_b;

	logic [AW-1:0] i0_q, i1;
	logic          v0_q, v1_q;
	logic [15:0]   x0_q, x1_q;

	logic [16:0] dnum_q;
	logic [8:0]  dden_q, drem_q, dquo_q;
	logic [4:0]  dcnt_q;
	logic        dbusy_q;

	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	scp_ram #(.WIDTH(32), .DEPTH(BUF_SIZE)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (s_tdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Datapath helpers.
	logic [31:0]        ph;
	logic [14:0]        tri_a, tri_b;
	logic signed [35:0] sh8, sh6, sh7;
	logic signed [17:0] lfo;
	logic signed [19:0] dq8;
	logic signed [11:0] d_raw;
	logic [AW-1:0]      d_cl;
	logic [7:0]         f_cl;
	logic [AW-1:0]      i0_new;
	logic [15:0]        x0e, x1e, din_ch;
	logic signed [35:0] wet_sum;
	logic [7:0]         depth, dry;
	logic [9:0]         r2;
	logic               ge;
	logic               out_load;

	assign ph     = phase_q + (ch_q ? PHASE_QUARTER : 32'd0);
	assign tri_a  = tri_wave(ph[31:24]);
	assign tri_b  = tri_wave(8'(ph[31:24] + 8'd1));
	assign sh8    = prod_q >>> 8;
	assign sh6    = prod_q >>> 6;
	assign sh7    = (acc_q + prod_q) >>> 7;
	assign lfo    = tria_q + sh8[17:0];
	assign dq8    = 20'(DELAY_BASE_Q8) + sh6[19:0];
	assign d_raw  = dq8[19:8];
	assign x0e    = v0_q ? x0_q : 16'd0;
	assign x1e    = v1_q ? x1_q : 16'd0;
	assign din_ch = ch_q ? din_q[31:16] : din_q[15:0];
	assign wet_sum = prod_q + $signed({{12{x1e[15]}}, x1e, 8'd0});
	assign depth  = (mix_q > DEPTH_FULL) ? DEPTH_FULL : mix_q;
	assign dry    = 8'(DEPTH_FULL - depth);
	assign i1     = (i0_q == '0) ? AW'(BUF_SIZE - 1) : AW'(i0_q - 1'b1);
	assign r2     = {drem_q, dnum_q[16]};
	assign ge     = r2 >= {1'b0, dden_q};
	assign out_load = (state_q == ST_DONE) && (!m_tvalid || m_tready);

	always_comb begin
		if (d_raw < 12'sd1) begin
			d_cl = AW'(1);
			f_cl = 8'd0;
		end else if (int'(d_raw) >= BUF_SIZE - 1) begin
			d_cl = AW'(BUF_SIZE - 2);
			f_cl = 8'd0;
		end else begin
			d_cl = AW'(d_raw);
			f_cl = dq8[7:0];
		end
		if (wp_q >= d_cl) begin
			i0_new = AW'(wp_q - d_cl);
		end else begin
			i0_new = AW'((AW+1)'(wp_q) + (AW+1)'(BUF_SIZE) - (AW+1)'(d_cl));
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_STEP;
			ST_STEP:  state_d = ST_PHASE;
			ST_PHASE: state_d = ST_LFO;
			ST_LFO:   state_d = ST_DLY;
			ST_DLY:   state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_RD1;
			ST_RD1:   state_d = ST_RD2;
			ST_RD2:   state_d = ST_RD3;
			ST_RD3:   state_d = ST_DIV;
			ST_DIV:   if (!dbusy_q) state_d = ST_AP;
			ST_AP:    state_d = ST_WET;
			ST_WET:   state_d = ch_q ? ST_MIXA : ST_LFO;
			ST_MIXA:  state_d = ST_MIXB;
			ST_MIXB:  state_d = ST_MIXC;
			ST_MIXC:  state_d = ch_q ? ST_DONE : ST_MIXA;
			ST_DONE:  if (!m_tvalid || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control outputs and shared multiplier operands.
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = i0_q;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ram_we   = s_tvalid;
			end
			ST_STEP: begin
				mul_a = $signed({11'd0, rate_q});
				mul_b = 18'(RATE_STEP);
			end
			ST_LFO: begin
				mul_a = $signed({3'd0, tri_b}) - $signed({3'd0, tri_a});
				mul_b = $signed({10'd0, ph[23:16]});
			end
			ST_DLY: begin
				mul_a = lfo - 18'(LFO_MID);
				mul_b = 18'(DELAY_SWING);
			end
			ST_RD2: ram_raddr = i1;
			ST_AP: begin
				mul_a = $signed({9'd0, dquo_q});
				mul_b = $signed({{2{x0e[15]}}, x0e}) - $signed({{2{mem_q[ch_q][15]}}, mem_q[ch_q]});
			end
			ST_MIXA: begin
				mul_a = $signed({{2{din_ch[15]}}, din_ch});
				mul_b = $signed({10'd0, dry});
			end
			ST_MIXB: begin
				mul_a = $signed({{2{wet_q[ch_q][15]}}, wet_q[ch_q]});
				mul_b = $signed({10'd0, depth});
			end
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mix_q    <= MIX_DEPTH_RESET;
			rate_q   <= LFO_RATE_RESET;
			phase_q  <= '0;
			wp_q     <= '0;
			fill_q   <= '0;
			ch_q     <= 1'b0;
			mem_q[0] <= '0;
			mem_q[1] <= '0;
			m_tvalid <= 1'b0;
			dbusy_q  <= 1'b0;
			dcnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					REG_MIX_DEPTH: mix_q  <= cfg_data;
					REG_LFO_RATE:  rate_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_PHASE: begin
					phase_q <= phase_q + PHASE_BASE + prod_q[31:0];
					ch_q    <= 1'b0;
				end
				ST_CLAMP: begin
					dbusy_q <= 1'b1;
					dcnt_q  <= '0;
				end
				ST_WET: begin
					mem_q[ch_q] <= sat16(wet_sum >>> 8);
					ch_q        <= ~ch_q;
				end
				ST_MIXC: ch_q <= ~ch_q;
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						wp_q     <= (wp_q == AW'(BUF_SIZE - 1)) ? '0 : AW'(wp_q + 1'b1);
						if (fill_q != (AW+1)'(BUF_SIZE)) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
			if (dbusy_q) begin
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == DIV_STEPS - 5'd1) begin
					dbusy_q <= 1'b0;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE:  din_q <= s_tdata;
			ST_LFO:   tria_q <= $signed({3'd0, tri_a});
			ST_CLAMP: begin
				i0_q   <= i0_new;
				v0_q   <= (AW+1)'(d_cl) <= fill_q;
				v1_q   <= (AW+1)'(d_cl) < fill_q;
				dnum_q <= {9'(9'd256 - {1'b0, f_cl}), 8'd0};
				dden_q <= 9'(9'd256 + {1'b0, f_cl});
				drem_q <= '0;
				dquo_q <= '0;
			end
			ST_RD2:  x0_q <= ch_q ? ram_rdata[31:16] : ram_rdata[15:0];
			ST_RD3:  x1_q <= ch_q ? ram_rdata[31:16] : ram_rdata[15:0];
			ST_WET:  wet_q[ch_q] <= sat16(wet_sum >>> 8);
			ST_MIXB: acc_q <= prod_q;
			ST_MIXC: res_q[ch_q] <= sat16(sh7);
			ST_DONE: begin
				if (!m_tvalid || m_tready) begin
					m_tdata <= {res_q[1], res_q[0]};
				end
			end
			default: ;
		endcase
		// One restoring divide step per cycle while the divider is running.
		if (dbusy_q) begin
			drem_q <= ge ? 9'(r2 - {1'b0, dden_q}) : r2[8:0];
			dquo_q <= {dquo_q[7:0], ge};
			dnum_q <= {dnum_q[15:0], 1'b0};
		end
	end

endmodule

/* hw/rtl/scp_chk.sv */
module scp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// A pending result stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item dropped or changed while stalled");

	// After an item is accepted the block is busy working on it.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again right after an item");

	// A new result never appears in the cycle right after an input is accepted.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared too early");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not taken");

endmodule

bind stereo_chorus_allpass scp_chk u_scp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
